### design/b32enc_pkg.sv
package b32enc_pkg;

    localparam int MAX_PREFIX = 83;
    localparam int MAX_TOTAL  = 90;

    localparam int CNT_W  = 7;
    localparam int PFX_AW = $clog2(MAX_PREFIX);
    localparam int ACC_W  = 30;

    localparam logic [ACC_W-1:0] GEN [5] = '{
        30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
    };

    localparam logic [ACC_W-1:0] XOR_BECH32  = 30'h00000001;
    localparam logic [ACC_W-1:0] XOR_BECH32M = 30'h2bc830a3;

    // first character sits in the top byte
    localparam logic [255:0] ALPHA_STR = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

    localparam logic [6:0] SEP_CHAR = 7'h31;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_BAD_CHAR = 3'd1;
    localparam logic [2:0] ERR_PFX_LEN  = 3'd2;
    localparam logic [2:0] ERR_RANGE    = 3'd3;
    localparam logic [2:0] ERR_TOTAL    = 3'd4;

    // checksum accumulator operations
    localparam logic [2:0] PM_NONE     = 3'd0;
    localparam logic [2:0] PM_PFX      = 3'd1;
    localparam logic [2:0] PM_ZERO     = 3'd2;
    localparam logic [2:0] PM_ZERO_XOR = 3'd3;
    localparam logic [2:0] PM_FOLD     = 3'd4;
    localparam logic [2:0] PM_DATA     = 3'd5;
    localparam logic [2:0] PM_SHIFT    = 3'd6;

    // output character sources
    localparam logic [1:0] EMIT_PFX  = 2'd0;
    localparam logic [1:0] EMIT_SEP  = 2'd1;
    localparam logic [1:0] EMIT_DATA = 2'd2;
    localparam logic [1:0] EMIT_CSUM = 2'd3;

    typedef struct packed {
        logic       load_item;
        logic [2:0] pm_sel;
        logic [1:0] emit_sel;
        logic       emit;
        logic       eos;
        logic       fold_start;
        logic       enter_data;
        logic       data_inc;
        logic       clear;
    } t_dp_cmd;

    typedef struct packed {
        logic item_op;
        logic item_last;
        logic in_data;
        logic has_prefix;
        logic fold_last;
        logic out_free;
    } t_dp_status;

    function automatic logic [ACC_W-1:0] pm_step(input logic [ACC_W-1:0] acc,
                                                 input logic [4:0] v);
        logic [4:0]       top;
        logic [ACC_W-1:0] res;
        top = acc[ACC_W-1:ACC_W-5];
        res = {acc[ACC_W-6:0], v};
        for (int k = 0; k < 5; k++) begin
            if (top[k]) begin
                res = res ^ GEN[k];
            end
        end
        return res;
    endfunction

    function automatic logic [6:0] alpha_char(input logic [4:0] sym);
        logic [7:0] pos;
        pos = {~sym, 3'b000};
        return ALPHA_STR[pos +: 7];
    endfunction

endpackage

### design/b32enc_datapath.sv
module b32enc_datapath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_wdata,
    input  logic                   i_op,
    input  logic [7:0]             i_value,
    input  logic                   i_last,
    input  logic                   i_out_ready,
    input  b32enc_pkg::t_dp_cmd    i_cmd,
    output b32enc_pkg::t_dp_status o_status,
    output logic                   o_out_valid,
    output logic [6:0]             o_char_out,
    output logic [2:0]             o_error_code,
    output logic                   o_end_of_string
);

    logic                              r_variant;
    logic                              r_op;
    logic [7:0]                        r_val;
    logic                              r_last;
    logic [b32enc_pkg::ACC_W-1:0]      r_acc;
    logic [b32enc_pkg::ACC_W-1:0]      n_acc;
    logic [b32enc_pkg::CNT_W-1:0]      r_pfx_cnt;
    logic [b32enc_pkg::CNT_W-1:0]      r_data_cnt;
    logic                              r_in_data;
    logic [2:0]                        r_err;
    logic [b32enc_pkg::CNT_W-1:0]      r_fold_idx;
    logic [4:0]                        r_rd_data;
    logic [4:0]                        r_pfx_mem [b32enc_pkg::MAX_PREFIX];
    logic                              r_out_valid;
    logic [6:0]                        r_char;
    logic [2:0]                        r_err_out;
    logic                              r_eos;

    logic [7:0]                        lc;
    logic                              pfx_ok;
    logic                              out_free;
    logic [b32enc_pkg::CNT_W-1:0]      data_sat;
    logic [8:0]                        total_pfx;
    logic [8:0]                        total_data;
    logic [2:0]                        item_err;
    logic                              rd_en;
    logic [b32enc_pkg::PFX_AW-1:0]     rd_addr;
    logic [6:0]                        emit_char;
    logic                              wr_en;

    localparam logic [8:0] TOTAL_LIMIT = 9'(b32enc_pkg::MAX_TOTAL);
    localparam logic [b32enc_pkg::CNT_W-1:0] PFX_LIMIT =
        b32enc_pkg::CNT_W'(b32enc_pkg::MAX_PREFIX);

    assign lc       = (r_val >= 8'h41 && r_val <= 8'h5a) ? r_val + 8'd32 : r_val;
    assign pfx_ok   = !r_in_data && (r_pfx_cnt < PFX_LIMIT);
    assign out_free = !r_out_valid || i_out_ready;
    assign data_sat = (r_data_cnt == {b32enc_pkg::CNT_W{1'b1}}) ? r_data_cnt
                                                                : r_data_cnt + 1'b1;
    // prefix item counts itself, then separator and checksum
    assign total_pfx  = {2'b00, r_pfx_cnt} + 9'd8 + {2'b00, r_data_cnt};
    assign total_data = {2'b00, r_pfx_cnt} + 9'd7 + {2'b00, data_sat};

    // first error that this word raises, in check order
    always_comb begin
        item_err = b32enc_pkg::ERR_NONE;
        if (!i_op) begin
            if (r_in_data) begin
                item_err = b32enc_pkg::ERR_BAD_CHAR;
            end else if (r_pfx_cnt >= PFX_LIMIT) begin
                item_err = b32enc_pkg::ERR_PFX_LEN;
            end else if (i_value < 8'd33 || i_value > 8'd126) begin
                item_err = b32enc_pkg::ERR_BAD_CHAR;
            end else if (total_pfx > TOTAL_LIMIT) begin
                item_err = b32enc_pkg::ERR_TOTAL;
            end
        end else begin
            if (!r_in_data && r_pfx_cnt == '0) begin
                item_err = b32enc_pkg::ERR_PFX_LEN;
            end else if (i_value > 8'd31) begin
                item_err = b32enc_pkg::ERR_RANGE;
            end else if (total_data > TOTAL_LIMIT) begin
                item_err = b32enc_pkg::ERR_TOTAL;
            end
        end
    end

    always_comb begin
        n_acc = r_acc;
        unique case (i_cmd.pm_sel)
            b32enc_pkg::PM_NONE: n_acc = r_acc;
            b32enc_pkg::PM_PFX: begin
                if (pfx_ok) begin
                    n_acc = b32enc_pkg::pm_step(r_acc, {2'b00, lc[7:5]});
                end
            end
            b32enc_pkg::PM_ZERO:  n_acc = b32enc_pkg::pm_step(r_acc, 5'd0);
            b32enc_pkg::PM_ZERO_XOR: begin
                n_acc = b32enc_pkg::pm_step(r_acc, 5'd0)
                        ^ (r_variant ? b32enc_pkg::XOR_BECH32M : b32enc_pkg::XOR_BECH32);
            end
            b32enc_pkg::PM_FOLD:  n_acc = b32enc_pkg::pm_step(r_acc, r_rd_data);
            b32enc_pkg::PM_DATA:  n_acc = b32enc_pkg::pm_step(r_acc, r_val[4:0]);
            b32enc_pkg::PM_SHIFT: n_acc = {r_acc[b32enc_pkg::ACC_W-6:0], 5'd0};
            default:              n_acc = r_acc;
        endcase
        if (i_cmd.clear) begin
            n_acc = b32enc_pkg::ACC_W'(1);
        end
    end

    always_comb begin
        case (i_cmd.emit_sel)
            b32enc_pkg::EMIT_PFX:  emit_char = lc[6:0];
            b32enc_pkg::EMIT_SEP:  emit_char = b32enc_pkg::SEP_CHAR;
            b32enc_pkg::EMIT_DATA: emit_char = b32enc_pkg::alpha_char(r_val[4:0]);
            default:               emit_char = b32enc_pkg::alpha_char(
                                       r_acc[b32enc_pkg::ACC_W-1:b32enc_pkg::ACC_W-5]);
        endcase
    end

    // prefix store: written in order, replayed after the separator
    assign wr_en   = (i_cmd.pm_sel == b32enc_pkg::PM_PFX) && pfx_ok;
    assign rd_en   = i_cmd.fold_start
                     || ((i_cmd.pm_sel == b32enc_pkg::PM_FOLD) && (r_fold_idx < r_pfx_cnt));
    assign rd_addr = i_cmd.fold_start ? '0 : r_fold_idx[b32enc_pkg::PFX_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_pfx_mem[r_pfx_cnt[b32enc_pkg::PFX_AW-1:0]] <= lc[4:0];
        end
        if (rd_en) begin
            r_rd_data <= r_pfx_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op   <= i_op;
            r_val  <= i_value;
            r_last <= i_last;
        end
        if (i_cmd.emit) begin
            r_char    <= emit_char;
            r_err_out <= r_err;
            r_eos     <= i_cmd.eos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant   <= 1'b0;
            r_acc       <= b32enc_pkg::ACC_W'(1);
            r_pfx_cnt   <= '0;
            r_data_cnt  <= '0;
            r_in_data   <= 1'b0;
            r_err       <= b32enc_pkg::ERR_NONE;
            r_fold_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_variant <= i_cfg_wdata;
            end
            r_acc <= n_acc;
            if (i_cmd.load_item && r_err == b32enc_pkg::ERR_NONE) begin
                r_err <= item_err;
            end
            if (wr_en) begin
                r_pfx_cnt <= r_pfx_cnt + 1'b1;
            end
            if (i_cmd.data_inc) begin
                r_data_cnt <= data_sat;
            end
            if (i_cmd.enter_data) begin
                r_in_data <= 1'b1;
            end
            if (i_cmd.fold_start) begin
                r_fold_idx <= b32enc_pkg::CNT_W'(1);
            end else if (i_cmd.pm_sel == b32enc_pkg::PM_FOLD) begin
                r_fold_idx <= r_fold_idx + 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.clear) begin
                r_pfx_cnt  <= '0;
                r_data_cnt <= '0;
                r_in_data  <= 1'b0;
                r_err      <= b32enc_pkg::ERR_NONE;
            end
        end
    end

    assign o_status.item_op    = r_op;
    assign o_status.item_last  = r_last;
    assign o_status.in_data    = r_in_data;
    assign o_status.has_prefix = (r_pfx_cnt != '0);
    assign o_status.fold_last  = (r_fold_idx == r_pfx_cnt);
    assign o_status.out_free   = out_free;

    assign o_out_valid     = r_out_valid;
    assign o_char_out      = r_char;
    assign o_error_code    = r_err_out;
    assign o_end_of_string = r_eos;

endmodule

### design/b32enc_ctrl.sv
module b32enc_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_op,
    input  b32enc_pkg::t_dp_status i_status,
    output logic                   o_in_ready,
    output b32enc_pkg::t_dp_cmd    o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PFX  = 3'd1;
    localparam logic [2:0] ST_SEP  = 3'd2;
    localparam logic [2:0] ST_FOLD = 3'd3;
    localparam logic [2:0] ST_DATA = 3'd4;
    localparam logic [2:0] ST_ZERO = 3'd5;
    localparam logic [2:0] ST_CSUM = 3'd6;

    localparam logic [2:0] LAST_STEP = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [2:0] r_step;
    logic [2:0] n_step;

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_state    = r_state;
        n_step     = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    if (!i_op) begin
                        n_state = ST_PFX;
                    end else begin
                        n_state = i_status.in_data ? ST_DATA : ST_SEP;
                    end
                end
            end
            ST_PFX: begin
                if (i_status.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = b32enc_pkg::EMIT_PFX;
                    o_cmd.pm_sel   = b32enc_pkg::PM_PFX;
                    if (!i_status.item_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = i_status.in_data ? ST_ZERO : ST_SEP;
                    end
                end
            end
            ST_SEP: begin
                if (i_status.out_free) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.emit_sel   = b32enc_pkg::EMIT_SEP;
                    o_cmd.pm_sel     = b32enc_pkg::PM_ZERO;
                    o_cmd.fold_start = 1'b1;
                    o_cmd.enter_data = 1'b1;
                    if (i_status.has_prefix) begin
                        n_state = ST_FOLD;
                    end else begin
                        n_state = i_status.item_op ? ST_DATA : ST_ZERO;
                    end
                end
            end
            ST_FOLD: begin
                // one stored prefix symbol per cycle
                o_cmd.pm_sel = b32enc_pkg::PM_FOLD;
                if (i_status.fold_last) begin
                    n_state = i_status.item_op ? ST_DATA : ST_ZERO;
                end
            end
            ST_DATA: begin
                if (i_status.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = b32enc_pkg::EMIT_DATA;
                    o_cmd.pm_sel   = b32enc_pkg::PM_DATA;
                    o_cmd.data_inc = 1'b1;
                    n_state        = i_status.item_last ? ST_ZERO : ST_IDLE;
                end
            end
            ST_ZERO: begin
                n_step = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    o_cmd.pm_sel = b32enc_pkg::PM_ZERO_XOR;
                    n_step       = '0;
                    n_state      = ST_CSUM;
                end else begin
                    o_cmd.pm_sel = b32enc_pkg::PM_ZERO;
                end
            end
            ST_CSUM: begin
                n_step = r_step;
                if (i_status.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = b32enc_pkg::EMIT_CSUM;
                    o_cmd.pm_sel   = b32enc_pkg::PM_SHIFT;
                    n_step         = r_step + 1'b1;
                    if (r_step == LAST_STEP) begin
                        o_cmd.eos   = 1'b1;
                        o_cmd.clear = 1'b1;
                        n_step      = '0;
                        n_state     = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

### design/bech32_string_encoder_unit.sv
// Each prefix or data word is taken in the idle state and emitted from its own state once the output is free.
// The first data word (or a prefix-only last word) also emits the separator and then
// replays the stored prefix symbols through the checksum step.
// A last word adds 6 checksum steps and 6 checksum characters; one word in flight.
// Reset (i_rst_n low, synchronous): string state cleared, variant = Bech32;
// the prefix store is not cleared and needs no clearing pass.
module bech32_string_encoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_op,
    input  logic [7:0] i_value,
    input  logic       i_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [6:0] o_char_out,
    output logic [2:0] o_error_code,
    output logic       o_end_of_string
);

    b32enc_pkg::t_dp_cmd    cmd;
    b32enc_pkg::t_dp_status status;

    b32enc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    b32enc_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_op            (i_op),
        .i_value         (i_value),
        .i_last          (i_last),
        .i_out_ready     (i_out_ready),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_out_valid     (o_out_valid),
        .o_char_out      (o_char_out),
        .o_error_code    (o_error_code),
        .o_end_of_string (o_end_of_string)
    );

    a_no_emit_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> status.out_free)
        else $error("word emitted over an untaken output word");

    a_clean_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear |=> (!status.in_data && !status.has_prefix))
        else $error("string state not cleared after last checksum word");

    a_idle_no_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !cmd.emit)
        else $error("output word produced while taking input");

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_error_code <= b32enc_pkg::ERR_TOTAL))
        else $error("error code out of range");

endmodule

### tb/b32enc_stream_checker.sv
module b32enc_stream_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic       i_op,
    input  logic [7:0] i_value,
    input  logic       i_last,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [6:0] i_char_out,
    input  logic [2:0] i_error_code,
    input  logic       i_end_of_string,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [29:0] G0 = 30'h3b6a57b2;
    localparam logic [29:0] G1 = 30'h26508e6d;
    localparam logic [29:0] G2 = 30'h1ea119fa;
    localparam logic [29:0] G3 = 30'h3d4233dd;
    localparam logic [29:0] G4 = 30'h2a1462b3;
    localparam logic [29:0] FINAL_B32  = 30'h00000001;
    localparam logic [29:0] FINAL_B32M = 30'h2bc830a3;
    // symbol 0 sits in the top byte
    localparam logic [255:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

    typedef struct packed {
        logic [6:0] ch;
        logic [2:0] err;
        logic       eos;
    } t_out_word;

    t_out_word   expected_chars[$];
    t_out_word   item_chars[$];

    logic        variant;
    logic [29:0] bch_acc;
    logic [4:0]  prefix_low [b32enc_pkg::MAX_PREFIX];
    int          prefix_len;
    int          data_len;
    logic        in_data;
    logic [2:0]  err_latch;

    function automatic logic [29:0] bch_fold(input logic [29:0] a, input logic [4:0] v);
        logic [4:0] t;
        t = a[29:25];
        return {a[24:0], v} ^ ({30{t[0]}} & G0) ^ ({30{t[1]}} & G1) ^
               ({30{t[2]}} & G2) ^ ({30{t[3]}} & G3) ^ ({30{t[4]}} & G4);
    endfunction

    function automatic logic [6:0] symbol_char(input logic [4:0] s);
        logic [7:0] b;
        b = CHARSET[8 * (31 - int'(s)) +: 8];
        return b[6:0];
    endfunction

    function automatic t_out_word make_word(input logic [6:0] ch, input logic eos);
        t_out_word w;
        w.ch  = ch;
        w.err = b32enc_pkg::ERR_NONE;
        w.eos = eos;
        return w;
    endfunction

    task automatic add_item_word(input t_out_word w);
        item_chars = {item_chars, w};
    endtask

    task automatic clear_string();
        bch_acc    = 30'd1;
        prefix_len = 0;
        data_len   = 0;
        in_data    = 1'b0;
        err_latch  = b32enc_pkg::ERR_NONE;
    endtask

    task automatic raise_err(input logic [2:0] code);
        if (err_latch == b32enc_pkg::ERR_NONE) begin
            err_latch = code;
        end
    endtask

    task automatic check_total();
        if (prefix_len + 1 + data_len + 6 > b32enc_pkg::MAX_TOTAL) begin
            raise_err(b32enc_pkg::ERR_TOTAL);
        end
    endtask

    // '1', then a zero and the stored low halves of the prefix
    task automatic emit_separator();
        add_item_word(make_word(b32enc_pkg::SEP_CHAR, 1'b0));
        bch_acc = bch_fold(bch_acc, 5'd0);
        for (int i = 0; i < prefix_len; i++) begin
            bch_acc = bch_fold(bch_acc, prefix_low[i]);
        end
        in_data = 1'b1;
    endtask

    task automatic predict_chars(input logic op, input logic [7:0] val, input logic last);
        logic [7:0]  c;
        logic [29:0] m;
        t_out_word   w;
        item_chars.delete();
        if (!op) begin
            c = val;
            if (c >= 8'h41 && c <= 8'h5a) begin
                c = c + 8'd32;
            end
            add_item_word(make_word(c[6:0], 1'b0));
            if (in_data) begin
                raise_err(b32enc_pkg::ERR_BAD_CHAR);
            end else if (prefix_len >= b32enc_pkg::MAX_PREFIX) begin
                raise_err(b32enc_pkg::ERR_PFX_LEN);
            end else begin
                if (val < 8'd33 || val > 8'd126) begin
                    raise_err(b32enc_pkg::ERR_BAD_CHAR);
                end
                bch_acc = bch_fold(bch_acc, {2'b00, c[7:5]});
                prefix_low[prefix_len] = c[4:0];
                prefix_len++;
                check_total();
            end
            if (last && !in_data) begin
                emit_separator();
            end
        end else begin
            if (!in_data) begin
                if (prefix_len == 0) begin
                    raise_err(b32enc_pkg::ERR_PFX_LEN);
                end
                emit_separator();
            end
            if (val > 8'd31) begin
                raise_err(b32enc_pkg::ERR_RANGE);
            end
            add_item_word(make_word(symbol_char(val[4:0]), 1'b0));
            bch_acc = bch_fold(bch_acc, val[4:0]);
            if (data_len < 127) begin
                data_len++;
            end
            check_total();
        end
        if (last) begin
            for (int k = 0; k < 6; k++) begin
                bch_acc = bch_fold(bch_acc, 5'd0);
            end
            m = bch_acc ^ (variant ? FINAL_B32M : FINAL_B32);
            for (int k = 0; k < 6; k++) begin
                add_item_word(make_word(symbol_char(m[5 * (5 - k) +: 5]), k == 5));
            end
        end
        // error field carries the latch as it stands after the word
        foreach (item_chars[i]) begin
            w = item_chars[i];
            w.err = err_latch;
            expected_chars = {expected_chars, w};
        end
        if (last) begin
            clear_string();
        end
    endtask

    task automatic check_char();
        t_out_word got;
        t_out_word want;
        got.ch  = i_char_out;
        got.err = i_error_code;
        got.eos = i_end_of_string;
        if (expected_chars.size() == 0) begin
            $display("%0t: expected nothing, got char %h err %0d eos %0b",
                     $time, got.ch, got.err, got.eos);
            o_fail_count++;
        end else begin
            want = expected_chars.pop_front();
            if (got !== want) begin
                $display("%0t: expected char %h err %0d eos %0b, got char %h err %0d eos %0b",
                         $time, want.ch, want.err, want.eos, got.ch, got.err, got.eos);
                o_fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            variant = 1'b0;
            clear_string();
            expected_chars.delete();
            o_fail_count = 0;
            o_pending = 0;
        end else begin
            if (i_cfg_we) begin
                variant = i_cfg_wdata;
            end
            if (i_in_valid && i_in_ready) begin
                predict_chars(i_op, i_value, i_last);
            end
            if (i_out_valid && i_out_ready) begin
                check_char();
            end
            o_pending = expected_chars.size();
        end
    end

endmodule

### tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 8;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic       cfg_wdata = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_op     = 1'b0;
    logic [7:0] in_value  = 8'd0;
    logic       in_last   = 1'b0;
    logic       out_ready = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic [6:0] char_out;
    logic [2:0] error_code;
    logic       end_of_string;

    int snd_pct = 0;
    int rcv_pct = 0;
    int fail_count;
    int pending;
    int words_sent = 0;
    int cycle_cnt = 0;

    bech32_string_encoder_unit u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_op            (in_op),
        .i_value         (in_value),
        .i_last          (in_last),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_char_out      (char_out),
        .o_error_code    (error_code),
        .o_end_of_string (end_of_string)
    );

    b32enc_stream_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_op            (in_op),
        .i_value         (in_value),
        .i_last          (in_last),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_char_out      (char_out),
        .i_error_code    (error_code),
        .i_end_of_string (end_of_string),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always #6 clk = ~clk;

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= rcv_pct);
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] pfx_char();
        int r;
        r = $urandom_range(99);
        if (r < 8) begin
            return 8'($urandom_range(255));
        end else if (r < 30) begin
            return 8'($urandom_range(90, 65));
        end else begin
            return 8'($urandom_range(126, 33));
        end
    endfunction

    // valid stays up across back-to-back words
    task automatic send_word(input logic op, input logic [7:0] val, input logic last);
        int gap;
        gap = 0;
        while (gap < 30 && $urandom_range(99) < snd_pct) begin
            gap++;
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_op    <= op;
        in_value <= val;
        in_last  <= last;
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_variant(input logic v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // plen == 0 gives an empty prefix; dlen == 0 ends on the prefix
    task automatic send_string(input int plen, input int dlen);
        for (int i = 0; i < plen; i++) begin
            send_word(1'b0, pfx_char(), dlen == 0 && i == plen - 1);
        end
        for (int i = 0; i < dlen; i++) begin
            send_word(1'b1, 8'($urandom_range(31)), i == dlen - 1);
        end
    endtask

    task automatic send_noise(input int n);
        logic       op;
        logic [7:0] v;
        for (int i = 0; i < n; i++) begin
            op = 1'($urandom_range(1));
            if (!op && $urandom_range(1)) begin
                v = pfx_char();
            end else begin
                v = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(31));
            end
            send_word(op, v, i == n - 1);
        end
    endtask

    task automatic run_strings(input int target);
        int r;
        while (words_sent < target) begin
            r = $urandom_range(99);
            if (r < 68) begin
                send_string($urandom_range(1, ($urandom_range(9) == 0) ? 20 : 6),
                            $urandom_range(10));
            end else if (r < 93) begin
                send_noise($urandom_range(1, 8));
            end else if (r < 94) begin
                send_string($urandom_range(80, 86), $urandom_range(3));
            end else if (r < 95) begin
                send_string($urandom_range(2, 6), $urandom_range(80, 84));
            end else begin
                send_string(0, $urandom_range(1, 5));
            end
            // occasional full drain, sometimes with a variant change
            if ($urandom_range(7) == 0) begin
                wait_idle();
                if ($urandom_range(1)) begin
                    write_variant(1'($urandom_range(1)));
                end
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_variant(1'b0);

        snd_pct = 20;
        rcv_pct = 73;
        // extremes of printable range, upper case folding
        send_word(1'b0, 8'h21, 1'b0);
        send_word(1'b0, 8'h7e, 1'b0);
        send_word(1'b0, "Z", 1'b0);
        send_word(1'b0, "m", 1'b0);
        send_word(1'b1, 8'd0, 1'b0);
        send_word(1'b1, 8'd31, 1'b1);
        // prefix-only string
        send_word(1'b0, "b", 1'b0);
        send_word(1'b0, "Q", 1'b1);
        // bad prefix characters
        send_word(1'b0, 8'h00, 1'b0);
        send_word(1'b0, 8'hff, 1'b0);
        send_word(1'b0, 8'h20, 1'b0);
        send_word(1'b0, 8'h7f, 1'b0);
        send_word(1'b1, 8'd16, 1'b1);
        // data value over 31
        send_word(1'b0, "x", 1'b0);
        send_word(1'b1, 8'h20, 1'b0);
        send_word(1'b1, 8'hff, 1'b1);
        // empty prefix
        send_word(1'b1, 8'd5, 1'b1);
        // prefix after data, closing on that prefix word
        send_word(1'b0, "a", 1'b0);
        send_word(1'b1, 8'd1, 1'b0);
        send_word(1'b0, "q", 1'b1);
        wait_idle();

        write_variant(1'b1);
        send_string(84, 1);
        run_strings(150);
        wait_idle();

        write_variant(1'b0);
        snd_pct = 73;
        rcv_pct = 20;
        send_string(5, 80);
        run_strings(260);
        wait_idle();

        write_variant(1'b1);
        snd_pct = 0;
        rcv_pct = 0;
        run_strings(345);
        wait_idle();
        repeat (20) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
